>>> hdl/cdc_pkg.sv
// Shared types, sizes and codes of the coherence directory controller.
// No dependencies; every other file of the block imports this package.
package cdc_pkg;

  // System sizes; all are powers of two.
  localparam int NODES            = 16;
  localparam int REGIONS          = 4;
  localparam int PAGES_PER_REGION = 256;
  localparam int PAGE_SIZE        = 4096;

  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int PAGE_W     = $clog2(PAGES_PER_REGION);
  localparam int REG_IDX_W  = $clog2(REGIONS);
  localparam int DIR_IDX_W  = REG_IDX_W + PAGE_W;
  localparam int DIR_DEPTH  = REGIONS * PAGES_PER_REGION;
  localparam int SCAN_W     = $clog2(NODES);
  localparam int NCNT_W     = $clog2(NODES + 1);

  // Incoming message codes.
  localparam logic [2:0] ACT_READ    = 3'd0;
  localparam logic [2:0] ACT_EXCL    = 3'd1;
  localparam logic [2:0] ACT_WBDATA  = 3'd2;
  localparam logic [2:0] ACT_IACK    = 3'd3;
  localparam logic [2:0] ACT_BENTER  = 3'd4;
  localparam logic [2:0] ACT_BLEAVE  = 3'd5;
  localparam logic [2:0] ACT_OTHER   = 3'd6;
  localparam logic [2:0] ACT_UNUSED  = 3'd7;

  // Outgoing message codes.
  localparam logic [2:0] OP_REPLY       = 3'd0;
  localparam logic [2:0] OP_REPLY_DIRTY = 3'd1;
  localparam logic [2:0] OP_WB_REQ      = 3'd2;
  localparam logic [2:0] OP_INVAL       = 3'd3;
  localparam logic [2:0] OP_GRANT       = 3'd4;
  localparam logic [2:0] OP_LEAVE       = 3'd5;

  // Directory entry states.
  localparam logic [1:0] DS_UNCACHED  = 2'd0;
  localparam logic [1:0] DS_SHARED    = 2'd1;
  localparam logic [1:0] DS_EXCLUSIVE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_OWN_NODE   = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]       state;
    logic [3:0]       owner;
    logic [NODES-1:0] sharers;
    logic [31:0]      epoch;
  } dir_entry_t;

  // Classified message passed from the front end to the back end.
  typedef struct packed {
    logic [2:0]           action;
    logic [3:0]           sender;
    logic [3:0]           home_node;
    logic [1:0]           region;
    logic [19:0]          page_offset;
    logic [31:0]          msg_epoch;
    logic [DIR_IDX_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic [3:0] own_node;
    logic [4:0] node_count;
  } cfg_t;

endpackage

>>> hdl/cdc_front.sv
// Front end: takes incoming messages, drops those without effect and
// computes the directory index. Depends on cdc_pkg.
module cdc_front import cdc_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_sender,
  input  logic [3:0]  in_home_node,
  input  logic [1:0]  in_region,
  input  logic [19:0] in_page_offset,
  input  logic [31:0] in_msg_epoch,
  input  logic        back_ready,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic [PAGE_W-1:0] page_num;
  logic              has_effect;

  // Page index and region select the directory entry.
  assign page_num = in_page_offset[PAGE_SHIFT +: PAGE_W];

  always_comb begin
    q_item.action      = in_action;
    q_item.sender      = in_sender;
    q_item.home_node   = in_home_node;
    q_item.region      = in_region;
    q_item.page_offset = in_page_offset;
    q_item.msg_epoch   = in_msg_epoch;
    q_item.idx         = {in_region[REG_IDX_W-1:0], page_num};
  end

  // Inval acks and unused codes change nothing and are consumed here.
  always_comb begin
    case (in_action)
      ACT_READ, ACT_EXCL, ACT_WBDATA, ACT_BENTER, ACT_BLEAVE: has_effect = 1'b1;
      default: has_effect = 1'b0;
    endcase
  end

  assign in_ready = back_ready && !q_full;
  assign q_push   = in_valid && in_ready && has_effect;

endmodule

>>> hdl/cdc_fifo.sv
// Two-entry queue of classified messages between front and back end.
// Depends on cdc_pkg for the item type.
module cdc_fifo import cdc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> hdl/cdc_back.sv
// Back end: directory memory, barrier state and the message sequencer
// that emits outgoing messages through an output register. Depends on cdc_pkg.
module cdc_back import cdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  item_t       head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_target,
  output logic [2:0]  out_op,
  output logic [3:0]  out_addr_node,
  output logic [1:0]  out_addr_region,
  output logic [19:0] out_addr_offset,
  output logic [31:0] out_epoch,
  output logic        out_last
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_INVAL = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;
  localparam logic [2:0] S_LEAVE = 3'd6;

  dir_entry_t dir_mem [DIR_DEPTH];

  logic [2:0]           state_r, state_nxt;
  logic [DIR_IDX_W-1:0] clr_r, clr_nxt;
  logic [SCAN_W-1:0]    scan_r, scan_nxt;
  logic [4:0]           bcnt_r, bcnt_nxt;
  logic [31:0]          gep_r, gep_nxt;
  item_t                item_r;
  dir_entry_t           ent_r;

  logic                 wr_en;
  logic [DIR_IDX_W-1:0] wr_addr;
  dir_entry_t           wr_data;

  logic        emit, can_emit, want, scan_end, wb_cond, leave_last;
  logic [3:0]  e_target;
  logic [2:0]  e_op;
  logic        e_addr;
  logic [31:0] e_epoch;
  logic        e_last;
  logic [NODES-1:0]  sbit;
  logic [NCNT_W-1:0] n_act;
  logic [4:0]        cnt1;

  // Effective node count, clamped to one through NODES.
  always_comb begin
    if (int'(cfg.node_count) > NODES) begin
      n_act = NCNT_W'(NODES);
    end else if (cfg.node_count == 5'd0) begin
      n_act = NCNT_W'(1);
    end else begin
      n_act = NCNT_W'(cfg.node_count);
    end
  end

  assign sbit       = NODES'(1) << item_r.sender;
  assign can_emit   = !out_valid || out_ready;
  assign wb_cond    = (ent_r.state == DS_EXCLUSIVE) && (ent_r.owner != item_r.sender);
  assign scan_end   = int'(scan_r) == int'(n_act) - 1;
  assign leave_last = scan_end || ((int'(scan_r) == int'(n_act) - 2) &&
                                   (int'(cfg.own_node) == int'(n_act) - 1));
  assign cnt1       = bcnt_r + 5'd1;
  assign ready      = (state_r != S_CLEAR);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    scan_nxt  = scan_r;
    bcnt_nxt  = bcnt_r;
    gep_nxt   = gep_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = item_r.idx;
    wr_data   = ent_r;
    emit      = 1'b0;
    want      = 1'b0;
    e_target  = item_r.sender;
    e_op      = OP_REPLY;
    e_addr    = 1'b1;
    e_epoch   = ent_r.epoch + 32'd1;
    e_last    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + DIR_IDX_W'(1);
        if (clr_r == DIR_IDX_W'(DIR_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        scan_nxt = '0;
        case (item_r.action)
          ACT_READ: begin
            state_nxt = (ent_r.state == DS_EXCLUSIVE) ? S_WB : S_FINAL;
          end
          ACT_EXCL: begin
            if (ent_r.sharers != '0) state_nxt = S_INVAL;
            else if (wb_cond)        state_nxt = S_WB;
            else                     state_nxt = S_FINAL;
          end
          ACT_WBDATA: begin
            wr_en         = 1'b1;
            wr_data.state = DS_UNCACHED;
            wr_data.epoch = ent_r.epoch + 32'd1;
            state_nxt     = S_IDLE;
          end
          ACT_BENTER: begin
            if (int'(cnt1) >= int'(n_act) - 1) begin
              state_nxt = S_LEAVE;
            end else begin
              bcnt_nxt  = cnt1;
              state_nxt = S_IDLE;
            end
          end
          ACT_BLEAVE: begin
            gep_nxt   = gep_r + 32'd1;
            state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INVAL: begin
        want     = ent_r.sharers[scan_r] && (int'(scan_r) != int'(cfg.own_node));
        e_target = 4'(scan_r);
        e_op     = OP_INVAL;
        e_addr   = 1'b0;
        e_epoch  = ent_r.epoch;
        if (!want || can_emit) begin
          emit = want;
          if (scan_end) state_nxt = wb_cond ? S_WB : S_FINAL;
          else          scan_nxt  = scan_r + SCAN_W'(1);
        end
      end
      S_WB: begin
        e_target = ent_r.owner;
        e_op     = OP_WB_REQ;
        e_epoch  = item_r.msg_epoch;
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (item_r.action == ACT_READ) begin
          e_op            = (ent_r.state == DS_EXCLUSIVE) ? OP_REPLY_DIRTY : OP_REPLY;
          wr_data.sharers = ent_r.sharers | sbit;
          wr_data.state   = (ent_r.state == DS_UNCACHED) ? DS_SHARED : ent_r.state;
        end else begin
          e_op            = OP_GRANT;
          wr_data.state   = DS_EXCLUSIVE;
          wr_data.owner   = item_r.sender;
          wr_data.sharers = sbit;
        end
        wr_data.epoch = ent_r.epoch + 32'd1;
        e_last        = 1'b1;
        if (can_emit) begin
          emit      = 1'b1;
          wr_en     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LEAVE: begin
        want     = int'(scan_r) != int'(cfg.own_node);
        e_target = 4'(scan_r);
        e_op     = OP_LEAVE;
        e_addr   = 1'b0;
        e_epoch  = gep_r;
        e_last   = leave_last;
        if (!want || can_emit) begin
          emit = want;
          if (scan_end) begin
            gep_nxt   = gep_r + 32'd1;
            bcnt_nxt  = 5'd0;
            state_nxt = S_IDLE;
          end else begin
            scan_nxt = scan_r + SCAN_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Directory memory with registered read on each transfer from the queue.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dir_mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      ent_r  <= dir_mem[head.idx];
      item_r <= head;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      scan_r  <= '0;
      bcnt_r  <= 5'd0;
      gep_r   <= 32'd0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      scan_r  <= scan_nxt;
      bcnt_r  <= bcnt_nxt;
      gep_r   <= gep_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_target      <= e_target;
      out_op          <= e_op;
      out_addr_node   <= e_addr ? item_r.home_node : 4'd0;
      out_addr_region <= e_addr ? item_r.region : 2'd0;
      out_addr_offset <= e_addr ? item_r.page_offset : 20'd0;
      out_epoch       <= e_epoch;
      out_last        <= e_last;
    end
  end

endmodule

>>> hdl/coherence_directory_controller.sv
// Top level of the home-node coherence directory controller.
// Instantiates cdc_front, cdc_fifo and cdc_back; depends on cdc_pkg.
//
// Usage:
//   Incoming coherence messages arrive on the in_ channel (valid/ready).
//   Outgoing messages leave on the out_ channel; out_last marks the final
//   message caused by one incoming message. Messages that cause nothing
//   (inval ack, unused codes) are taken and dropped by the front end.
//   Configuration: cfg_index 0 is own_node, 1 is node_count; cfg_ready is
//   always high and a transfer writes the register at once.
//   Sequencing: a transfer of a message with effect writes it into the
//   queue; while idle, the sequencer pops it and reads its directory
//   entry, decodes it, then emits its messages one at a time. Writeback
//   data, barrier leave and a barrier enter that releases nothing emit no
//   message. An exclusive request scans the nodes below the effective
//   node count when any sharer is set, plus a writeback request when
//   needed; a barrier release scans every node below that count. A
//   two-entry queue lets new messages be taken meanwhile.
//   Reset: a clearing pass zeroes all 1024 directory entries; in_ready
//   stays low during it. When the receiver stalls, the output register
//   holds its message and the sequencer waits.
module coherence_directory_controller import cdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_sender,
  input  logic [3:0]  in_home_node,
  input  logic [1:0]  in_region,
  input  logic [19:0] in_page_offset,
  input  logic [31:0] in_msg_epoch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_target,
  output logic [2:0]  out_op,
  output logic [3:0]  out_addr_node,
  output logic [1:0]  out_addr_region,
  output logic [19:0] out_addr_offset,
  output logic [31:0] out_epoch,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  cfg_t  cfg_r;
  item_t q_in, q_head;
  logic  q_push, q_pop, q_empty, q_full, back_ready;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node   <= 4'd0;
      cfg_r.node_count <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_NODE:   cfg_r.own_node   <= cfg_data[3:0];
        CFG_NODE_COUNT: cfg_r.node_count <= cfg_data;
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  cdc_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_sender      (in_sender),
    .in_home_node   (in_home_node),
    .in_region      (in_region),
    .in_page_offset (in_page_offset),
    .in_msg_epoch   (in_msg_epoch),
    .back_ready     (back_ready),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  cdc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cdc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .ready           (back_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_target      (out_target),
    .out_op          (out_op),
    .out_addr_node   (out_addr_node),
    .out_addr_region (out_addr_region),
    .out_addr_offset (out_addr_offset),
    .out_epoch       (out_epoch),
    .out_last        (out_last)
  );

endmodule

>>> dv/cdc_checker.sv
// Transfer monitor and directory predictor for the coherence directory controller.
// Depends on cdc_pkg; instantiated beside the block by coherence_directory_controller_tb.
`timescale 1ns / 100ps
module cdc_checker import cdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_sender,
  input  logic [3:0]  in_home_node,
  input  logic [1:0]  in_region,
  input  logic [19:0] in_page_offset,
  input  logic [31:0] in_msg_epoch,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_target,
  input  logic [2:0]  out_op,
  input  logic [3:0]  out_addr_node,
  input  logic [1:0]  out_addr_region,
  input  logic [19:0] out_addr_offset,
  input  logic [31:0] out_epoch,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          pending_msgs
);

  typedef struct packed {
    logic [3:0]  target;
    logic [2:0]  op;
    logic [3:0]  anode;
    logic [1:0]  aregion;
    logic [19:0] aoffset;
    logic [31:0] epoch;
    logic        last;
  } msg_t;

  dir_entry_t dir_model [DIR_DEPTH];
  logic [4:0]  barrier_cnt;
  logic [31:0] glob_epoch;
  logic [3:0]  home_id;
  logic [4:0]  sys_nodes;
  msg_t        expected_msgs[$];

  assign pending_msgs = expected_msgs.size();

  // Queue one outgoing message; address fields only for directory traffic.
  task automatic push_msg(input logic [3:0] tgt, input logic [2:0] op,
                          input logic with_addr, input logic [31:0] ep);
    msg_t m;
    m.target  = tgt;
    m.op      = op;
    m.anode   = with_addr ? in_home_node : 4'd0;
    m.aregion = with_addr ? in_region : 2'd0;
    m.aoffset = with_addr ? in_page_offset : 20'd0;
    m.epoch   = ep;
    m.last    = 1'b0;
    expected_msgs.push_back(m);
  endtask

  // Apply one incoming message to the directory copy and queue its results.
  task automatic predict_message();
    logic [DIR_IDX_W-1:0] idx;
    int unsigned n;
    int          first;
    dir_entry_t  e;
    msg_t        m;
    idx = {in_region, in_page_offset[PAGE_SHIFT +: PAGE_W]};
    n = (sys_nodes > NODES) ? NODES : ((sys_nodes == 0) ? 1 : sys_nodes);
    first = expected_msgs.size();
    e = dir_model[idx];
    case (in_action)
      ACT_READ: begin
        if (e.state == DS_EXCLUSIVE) push_msg(e.owner, OP_WB_REQ, 1'b1, in_msg_epoch);
        e.sharers[in_sender] = 1'b1;
        if (e.state == DS_UNCACHED) e.state = DS_SHARED;
        e.epoch = e.epoch + 32'd1;
        push_msg(in_sender, (e.state == DS_EXCLUSIVE) ? OP_REPLY_DIRTY : OP_REPLY,
                 1'b1, e.epoch);
      end
      ACT_EXCL: begin
        for (int i = 0; i < n; i++)
          if (i != home_id && e.sharers[i]) push_msg(i[3:0], OP_INVAL, 1'b0, e.epoch);
        if (e.state == DS_EXCLUSIVE && e.owner != in_sender)
          push_msg(e.owner, OP_WB_REQ, 1'b1, in_msg_epoch);
        e.state = DS_EXCLUSIVE;
        e.owner = in_sender;
        e.sharers = '0;
        e.sharers[in_sender] = 1'b1;
        e.epoch = e.epoch + 32'd1;
        push_msg(in_sender, OP_GRANT, 1'b1, e.epoch);
      end
      ACT_WBDATA: begin
        e.state = DS_UNCACHED;
        e.epoch = e.epoch + 32'd1;
      end
      ACT_BENTER: begin
        barrier_cnt = barrier_cnt + 5'd1;
        if (barrier_cnt >= n - 1) begin
          for (int i = 0; i < n; i++)
            if (i != home_id) push_msg(i[3:0], OP_LEAVE, 1'b0, glob_epoch);
          glob_epoch = glob_epoch + 32'd1;
          barrier_cnt = '0;
        end
      end
      ACT_BLEAVE: glob_epoch = glob_epoch + 32'd1;
      default: ;
    endcase
    dir_model[idx] = e;
    // Mark the final message caused by this input.
    if (expected_msgs.size() > first) begin
      m = expected_msgs.pop_back();
      m.last = 1'b1;
      expected_msgs.push_back(m);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Compare one outgoing transfer with the oldest expected message.
  task automatic check_message();
    msg_t exp_m;
    if (expected_msgs.size() == 0) begin
      report_mismatch($sformatf("unexpected message op %0d to node %0d", out_op, out_target));
      return;
    end
    exp_m = expected_msgs.pop_front();
    if (out_target !== exp_m.target)
      report_mismatch($sformatf("target %0d, want %0d", out_target, exp_m.target));
    if (out_op !== exp_m.op)
      report_mismatch($sformatf("op %0d, want %0d", out_op, exp_m.op));
    if (out_addr_node !== exp_m.anode)
      report_mismatch($sformatf("addr_node %0d, want %0d", out_addr_node, exp_m.anode));
    if (out_addr_region !== exp_m.aregion)
      report_mismatch($sformatf("addr_region %0d, want %0d", out_addr_region, exp_m.aregion));
    if (out_addr_offset !== exp_m.aoffset)
      report_mismatch($sformatf("addr_offset %h, want %h", out_addr_offset, exp_m.aoffset));
    if (out_epoch !== exp_m.epoch)
      report_mismatch($sformatf("epoch %h, want %h", out_epoch, exp_m.epoch));
    if (out_last !== exp_m.last)
      report_mismatch($sformatf("last %0b, want %0b", out_last, exp_m.last));
  endtask

  // Sample all three channels at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIR_DEPTH; i++) dir_model[i] = '0;
      barrier_cnt = '0;
      glob_epoch = '0;
      home_id = '0;
      sys_nodes = 5'd16;
      expected_msgs.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) check_message();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OWN_NODE) home_id = cfg_data[3:0];
        else sys_nodes = cfg_data;
      end
      if (in_valid && in_ready) predict_message();
    end
  end

endmodule

>>> dv/coherence_directory_controller_tb.sv
// Stimulus and verdict for the coherence directory controller.
// Depends on cdc_pkg, cdc_checker and the block itself.
`timescale 1ns / 100ps
module coherence_directory_controller_tb;
  import cdc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [2:0]  in_action;
  logic [3:0]  in_sender, in_home_node;
  logic [1:0]  in_region;
  logic [19:0] in_page_offset;
  logic [31:0] in_msg_epoch;
  logic        out_valid, out_ready;
  logic [3:0]  out_target, out_addr_node;
  logic [2:0]  out_op;
  logic [1:0]  out_addr_region;
  logic [19:0] out_addr_offset;
  logic [31:0] out_epoch;
  logic        out_last;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [4:0]  cfg_data;
  int          fail_count, pending_msgs;
  int          cycle_count;
  logic        hold_off;

  coherence_directory_controller dut (.*);

  cdc_checker checker_i (.*);

  // 12 ns clock.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Cycle limit guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** coherence_directory_controller: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall per message, plus a long hold-off on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (out_ready && out_valid) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
      end else out_ready <= 1'b1;
    end
  end

  // One incoming message; waits for its transfer. Valid drops only for a gap,
  // so back-to-back messages keep it high; the caller ends a burst.
  task automatic send_msg(input logic [2:0] act, input logic [3:0] snd,
                          input logic [1:0] reg_no, input logic [19:0] offs,
                          input logic [31:0] ep, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_sender      <= snd;
    in_home_node   <= 4'($urandom_range(0, 15));
    in_region      <= reg_no;
    in_page_offset <= offs;
    in_msg_epoch   <= ep;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Register write while idle: drain expectations, then allow the sequencer to settle.
  task automatic write_reg(input logic idx, input logic [4:0] val);
    while (pending_msgs != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Page offsets drawn from a few pages, so entries get revisited.
  function automatic logic [19:0] pick_offset();
    logic [19:0] o;
    o = 20'($urandom);
    o[19:12] = 8'($urandom_range(0, 3) * 85);
    return o;
  endfunction

  task automatic random_run(input int count, input bit fast);
    int r;
    logic [2:0] act;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      act = (r < 35) ? ACT_READ : (r < 60) ? ACT_EXCL : (r < 72) ? ACT_WBDATA :
            (r < 84) ? ACT_BENTER : (r < 90) ? ACT_BLEAVE :
            3'($urandom_range(ACT_IACK, ACT_UNUSED));
      if (act == ACT_IACK || act > ACT_BLEAVE) k--;
      send_msg(act, 4'($urandom), 2'($urandom), pick_offset(), $urandom,
               fast || (k % 40 < 6));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    in_valid = 1'b0;
    in_action = '0;
    in_sender = '0;
    in_home_node = '0;
    in_region = '0;
    in_page_offset = '0;
    in_msg_epoch = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OWN_NODE;
    cfg_data = '0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every action, dirty read, owner rerequest.
    send_msg(ACT_READ, 4'd0, 2'd0, 20'd0, 32'd0, 0);
    send_msg(ACT_READ, 4'd15, 2'd3, 20'hFFFFF, 32'hFFFFFFFF, 0);
    send_msg(ACT_READ, 4'd5, 2'd0, 20'd0, 32'h5A5A5A5A, 0);
    send_msg(ACT_EXCL, 4'd3, 2'd0, 20'h00FFF, 32'hA5A5A5A5, 0);
    send_msg(ACT_READ, 4'd7, 2'd0, 20'd0, 32'h12345678, 0);
    send_msg(ACT_EXCL, 4'd7, 2'd0, 20'd0, 32'd1, 0);
    send_msg(ACT_EXCL, 4'd7, 2'd0, 20'd0, 32'd2, 0);
    send_msg(ACT_EXCL, 4'd9, 2'd0, 20'd0, 32'd3, 0);
    send_msg(ACT_WBDATA, 4'd9, 2'd0, 20'd0, 32'd4, 0);
    send_msg(ACT_READ, 4'd1, 2'd0, 20'd0, 32'd5, 0);
    send_msg(ACT_EXCL, 4'd1, 2'd3, 20'hFFFFF, 32'd6, 0);
    send_msg(ACT_IACK, 4'd2, 2'd1, 20'h12345, 32'd7, 0);
    send_msg(ACT_OTHER, 4'd2, 2'd1, 20'h12345, 32'd8, 0);
    send_msg(ACT_UNUSED, 4'd2, 2'd1, 20'h12345, 32'd9, 0);
    send_msg(ACT_BLEAVE, 4'd0, 2'd0, 20'd0, 32'd0, 0);
    for (int i = 0; i < 15; i++) send_msg(ACT_BENTER, i[3:0], 2'd2, 20'd0, 32'd0, 1);

    // Random with default configuration, and a long receiver hold-off.
    random_run(60, 0);
    hold_off = 1'b1;
    fork
      random_run(30, 1);
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
    join

    // Own node at top, small system.
    write_reg(CFG_OWN_NODE, 5'd15);
    write_reg(CFG_NODE_COUNT, 5'd2);
    random_run(60, 0);
    // Over-range node count, home in the middle.
    write_reg(CFG_OWN_NODE, 5'd6);
    write_reg(CFG_NODE_COUNT, 5'd31);
    random_run(70, 0);
    // Node count zero acts as one.
    write_reg(CFG_NODE_COUNT, 5'd0);
    random_run(40, 0);
    write_reg(CFG_NODE_COUNT, 5'd1);
    random_run(30, 0);
    write_reg(CFG_OWN_NODE, 5'd0);
    write_reg(CFG_NODE_COUNT, 5'd5);
    random_run(70, 0);
    write_reg(CFG_NODE_COUNT, 5'd16);
    random_run(50, 0);

    // Drain and settle.
    while (pending_msgs != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("** coherence_directory_controller: PASSED **");
    else $display("** coherence_directory_controller: FAILED **");
    $finish;
  end

endmodule

>>> files.f
hdl/cdc_pkg.sv
hdl/cdc_front.sv
hdl/cdc_fifo.sv
hdl/cdc_back.sv
hdl/coherence_directory_controller.sv
dv/cdc_checker.sv
dv/coherence_directory_controller_tb.sv
